FILE: sv/lph_pkg.sv
// Package: types, codes, sizes and hash function for the linear probe hash table.
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;

  localparam int CAPACITY      = 64;
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int CNT_W         = IDX_W + 1;
  localparam int KEY_W         = 22;
  localparam int VAL_W         = 32;
  localparam int LOAD_W        = 6;
  localparam int HASH_W        = 32;
  localparam int HASH_SHIFT_HI = 11;
  localparam int HASH_SHIFT_LO = 3;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [LOAD_W-1:0] MAX_LOAD_RESET = LOAD_W'(16);

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_HIT    = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  // Register index on the configuration port
  localparam logic REG_MAX_LOAD = 1'b0;

  typedef struct packed {
    mode_t              mode;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   value_out;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } slot_t;

  typedef struct packed {
    logic               hit;
    logic               empty;
    logic               exhausted;
    logic [IDX_W-1:0]   idx_next;
    logic [IDX_W-1:0]   cnt_next;
  } probe_t;

  function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
    logic [HASH_W-1:0] kx;
    logic [HASH_W-1:0] h;
    kx = HASH_W'(k);
    h  = ((kx >> HASH_SHIFT_HI) | (kx << HASH_SHIFT_LO)) ^ (kx >> HASH_SHIFT_LO);
    return h[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/lph_slot_mem.sv
// Slot memory: key and value per slot, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lph_slot_mem (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [lph_pkg::IDX_W-1:0] wr_addr,
  input  wire lph_pkg::slot_t        wr_data,
  input  wire logic [lph_pkg::IDX_W-1:0] rd_addr,
  output lph_pkg::slot_t             rd_data
);

  lph_pkg::slot_t mem [lph_pkg::CAPACITY];
  lph_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/lph_cfg_regs.sv
// APB configuration register block holding max_load.
`timescale 1ns / 1ps
`default_nettype none
module lph_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lph_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [lph_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [lph_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready,
  output logic      [lph_pkg::LOAD_W-1:0]    max_load
);

  logic [lph_pkg::LOAD_W-1:0] max_load_r;
  logic [lph_pkg::LOAD_W-1:0] max_load_nxt;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[lph_pkg::CFG_ADDR_W-1] == lph_pkg::REG_MAX_LOAD);

  always_comb begin
    max_load_nxt = max_load_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      max_load_nxt = pwdata[lph_pkg::LOAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_load_r <= lph_pkg::MAX_LOAD_RESET;
    end else begin
      max_load_r <= max_load_nxt;
    end
  end

  assign prdata   = reg_sel ? lph_pkg::CFG_DATA_W'(max_load_r) : '0;
  assign max_load = max_load_r;

endmodule
`default_nettype wire

FILE: sv/lph_probe_unit.sv
// Probe unit: classifies one slot against the key and steps the probe index.
`timescale 1ns / 1ps
`default_nettype none
module lph_probe_unit (
  input  wire logic                     used_bit,
  input  wire logic                     grave_bit,
  input  wire logic [lph_pkg::KEY_W-1:0] slot_key,
  input  wire logic [lph_pkg::KEY_W-1:0] key,
  input  wire logic [lph_pkg::IDX_W-1:0] idx,
  input  wire logic [lph_pkg::IDX_W-1:0] cnt,
  output lph_pkg::probe_t               res
);

  always_comb begin
    res.hit       = used_bit && (slot_key == key);
    res.empty     = !used_bit && !grave_bit;
    res.exhausted = (cnt == lph_pkg::IDX_W'(lph_pkg::CAPACITY - 1));
    res.idx_next  = idx + lph_pkg::IDX_W'(1);
    res.cnt_next  = cnt + lph_pkg::IDX_W'(1);
  end

endmodule
`default_nettype wire

FILE: sv/linear_probe_hash_table.sv
// Top level: sequencer, slot state and counts of the linear probe hash table.
//
// Key-to-value table of 64 slots with linear probing and tombstones. One
// transaction is taken at a time: in_stall stays high from acceptance until
// the result is loaded into the output register. Each probed slot goes
// through a slot memory read, then a compare in the probe unit. Lookup,
// insert and delete probe a run of 1 to 64 slots; clear skips probing and
// goes straight to the response. Occupied and tombstone bits live in
// flops, so clear is immediate and there is no clearing pass after reset.
// A result waits in the output register while out_stall is high and the
// next transaction may be accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lph_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lph_pkg::out_t                      out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [lph_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [lph_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [lph_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                               cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  localparam int SUM_W = lph_pkg::CNT_W + 1;

  state_t                         state_r, state_nxt;
  lph_pkg::mode_t                 mode_r, mode_nxt;
  logic [lph_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [lph_pkg::VAL_W-1:0]      val_r, val_nxt;
  logic [lph_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [lph_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  lph_pkg::status_t               res_status_r, res_status_nxt;
  logic [lph_pkg::VAL_W-1:0]      res_value_r, res_value_nxt;
  logic [lph_pkg::CAPACITY-1:0]   used_r, used_nxt;
  logic [lph_pkg::CAPACITY-1:0]   grave_r, grave_nxt;
  logic [lph_pkg::CNT_W-1:0]      occ_r, occ_nxt;
  logic [lph_pkg::CNT_W-1:0]      tomb_r, tomb_nxt;
  logic                           out_valid_r, out_valid_nxt;
  lph_pkg::out_t                  out_data_r, out_data_nxt;

  logic                           in_accept;
  logic                           out_load;
  logic                           wr_en;
  lph_pkg::slot_t                 wr_data;
  lph_pkg::slot_t                 rd_slot;
  lph_pkg::probe_t                probe;
  logic [lph_pkg::LOAD_W-1:0]     max_load;
  logic                           room;

  lph_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .max_load (max_load)
  );

  lph_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_slot)
  );

  lph_probe_unit u_probe (
    .used_bit  (used_r[idx_r]),
    .grave_bit (grave_r[idx_r]),
    .slot_key  (rd_slot.key),
    .key       (key_r),
    .idx       (idx_r),
    .cnt       (cnt_r),
    .res       (probe)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign room      = (SUM_W'(occ_r) + SUM_W'(tomb_r)) < SUM_W'(max_load);
  assign wr_data   = '{key: key_r, value: val_r};

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    used_nxt       = used_r;
    grave_nxt      = grave_r;
    occ_nxt        = occ_r;
    tomb_nxt       = tomb_r;
    wr_en          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          mode_nxt      = in_data.mode;
          key_nxt       = in_data.key;
          val_nxt       = in_data.value;
          idx_nxt       = lph_pkg::home_slot(in_data.key);
          cnt_nxt       = '0;
          res_value_nxt = '0;
          if (in_data.mode == lph_pkg::MODE_CLEAR) begin
            used_nxt       = '0;
            grave_nxt      = '0;
            occ_nxt        = '0;
            tomb_nxt       = '0;
            res_status_nxt = lph_pkg::STAT_HIT;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (probe.hit || probe.empty || probe.exhausted) begin
          state_nxt      = S_RESP;
          res_status_nxt = lph_pkg::STAT_ABSENT;
          res_value_nxt  = '0;
          case (mode_r)
            lph_pkg::MODE_LOOKUP: begin
              if (probe.hit) begin
                res_status_nxt = lph_pkg::STAT_HIT;
                res_value_nxt  = rd_slot.value;
              end
            end
            lph_pkg::MODE_INSERT: begin
              if (probe.hit) begin
                res_status_nxt = lph_pkg::STAT_HIT;
                res_value_nxt  = rd_slot.value;
                wr_en          = 1'b1;
              end else if (probe.empty && room) begin
                wr_en             = 1'b1;
                used_nxt[idx_r]   = 1'b1;
                grave_nxt[idx_r]  = 1'b0;
                occ_nxt           = occ_r + lph_pkg::CNT_W'(1);
              end else begin
                res_status_nxt = lph_pkg::STAT_FULL;
              end
            end
            lph_pkg::MODE_DELETE: begin
              if (probe.hit) begin
                res_status_nxt   = lph_pkg::STAT_HIT;
                res_value_nxt    = rd_slot.value;
                used_nxt[idx_r]  = 1'b0;
                grave_nxt[idx_r] = 1'b1;
                if (occ_r != '0) begin
                  occ_nxt = occ_r - lph_pkg::CNT_W'(1);
                end
                tomb_nxt = tomb_r + lph_pkg::CNT_W'(1);
              end
            end
            default: begin
              res_status_nxt = lph_pkg::STAT_HIT;
            end
          endcase
        end else begin
          idx_nxt   = probe.idx_next;
          cnt_nxt   = probe.cnt_next;
          state_nxt = S_READ;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{status: res_status_r, value_out: res_value_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      grave_r     <= '0;
      occ_r       <= '0;
      tomb_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      grave_r     <= grave_nxt;
      occ_r       <= occ_nxt;
      tomb_r      <= tomb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupied count tracks the occupied bits
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(occ_r))
    else $error("occupied count out of step with slot bits");

  a_used_grave: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r & grave_r) == '0)
    else $error("slot both occupied and tombstoned");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.mode == lph_pkg::MODE_CLEAR) |=>
      (used_r == '0 && grave_r == '0 && tomb_r == '0))
    else $error("clear left slot state behind");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (SUM_W'(occ_r) + SUM_W'(tomb_r)) < SUM_W'(lph_pkg::CAPACITY))
    else $error("slot counts exceed capacity");

endmodule
`default_nettype wire
